// ===== design/gmcp_pkg.sv =====
// ----------------------------------------------------------------------------
// gmcp_pkg
// Shared types, constants and helpers of the grid minimum-cost-path block.
// ----------------------------------------------------------------------------
package gmcp_pkg;

    localparam int MAX_COLS = 1024;
    localparam int MAX_ROWS = 1024;
    localparam int COL_W    = $clog2(MAX_COLS);
    localparam int ROW_W    = $clog2(MAX_ROWS);
    localparam int SIZE_W   = 11;
    localparam int COST_W   = 16;
    localparam int SUM_W    = 32;
    localparam int QDEPTH   = 4;
    localparam int QPTR_W   = $clog2(QDEPTH);

    // Register indexes on the configuration port.
    localparam logic REG_GRID_ROWS = 1'b0;
    localparam logic REG_GRID_COLS = 1'b1;

    // Last row and last column index of the grid in use.
    typedef struct packed {
        logic [ROW_W-1:0] last_row;
        logic [COL_W-1:0] last_col;
    } t_grid_cfg;

    // One classified cell on its way from the front to the back.
    typedef struct packed {
        logic signed [COST_W-1:0] cost;
        logic [COL_W-1:0]         col;
        logic                     first_row;
        logic                     first_col;
        logic                     last;
    } t_cell_op;

    // A size of zero acts as one, a size above the maximum as the maximum.
    function automatic logic [ROW_W-1:0] last_row_index(input logic [SIZE_W-1:0] size);
        logic [ROW_W-1:0] r;
        if (size == '0) begin
            r = '0;
        end else if (32'(size) > MAX_ROWS) begin
            r = ROW_W'(MAX_ROWS - 1);
        end else begin
            r = ROW_W'(size - SIZE_W'(1));
        end
        return r;
    endfunction

    function automatic logic [COL_W-1:0] last_col_index(input logic [SIZE_W-1:0] size);
        logic [COL_W-1:0] r;
        if (size == '0) begin
            r = '0;
        end else if (32'(size) > MAX_COLS) begin
            r = COL_W'(MAX_COLS - 1);
        end else begin
            r = COL_W'(size - SIZE_W'(1));
        end
        return r;
    endfunction

endpackage

// ===== design/gmcp_if.sv =====
// ----------------------------------------------------------------------------
// gmcp_if
// Valid/ready channels for cell costs in and path costs out.
// ----------------------------------------------------------------------------
interface gmcp_cell_if;
    import gmcp_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [COST_W-1:0] cell_cost;
    modport source (output valid, output cell_cost, input ready);
    modport sink   (input valid, input cell_cost, output ready);
endinterface

interface gmcp_path_if;
    import gmcp_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [SUM_W-1:0] path_cost;
    modport source (output valid, output path_cost, input ready);
    modport sink   (input valid, input path_cost, output ready);
endinterface

// ===== design/gmcp_front.sv =====
// ----------------------------------------------------------------------------
// gmcp_front
// Accepts cell costs, tracks the raster position and tags each cell with
// its column and its place in the grid.
// ----------------------------------------------------------------------------
module gmcp_front
    import gmcp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_grid_cfg   i_cfg,
    input  logic        i_clear,
    gmcp_cell_if.sink   i_cell,
    input  logic        i_q_ready,
    output logic        o_q_valid,
    output t_cell_op    o_q_op
);

    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    logic             w_accept;
    logic             w_end_col;
    logic             w_end_row;

    assign i_cell.ready = i_q_ready;
    assign o_q_valid    = i_cell.valid;
    assign w_accept     = i_cell.valid && i_q_ready;
    assign w_end_col    = (r_col == i_cfg.last_col);
    assign w_end_row    = (r_row == i_cfg.last_row);

    always_comb begin
        o_q_op.cost      = i_cell.cell_cost;
        o_q_op.col       = r_col;
        o_q_op.first_row = (r_row == '0);
        o_q_op.first_col = (r_col == '0);
        o_q_op.last      = w_end_col && w_end_row;
    end

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        priority if (i_clear) begin
            n_col = '0;
            n_row = '0;
        end else if (w_accept) begin
            if (w_end_col) begin
                n_col = '0;
                n_row = w_end_row ? '0 : r_row + ROW_W'(1);
            end else begin
                n_col = r_col + COL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule

// ===== design/gmcp_queue.sv =====
// ----------------------------------------------------------------------------
// gmcp_queue
// Short FIFO of classified cells between the front and the back.
// ----------------------------------------------------------------------------
module gmcp_queue
    import gmcp_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_cell_op i_op,
    output logic     o_ready,
    output logic     o_valid,
    output t_cell_op o_op,
    input  logic     i_ready
);

    t_cell_op          r_slot [QDEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QPTR_W:0]   r_count;
    logic              w_push;
    logic              w_pop;

    assign o_ready = (r_count != (QPTR_W+1)'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_op    = r_slot[r_rptr];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wptr] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= r_wptr + QPTR_W'(1);
            end
            if (w_pop) begin
                r_rptr <= r_rptr + QPTR_W'(1);
            end
            r_count <= r_count + (QPTR_W+1)'(w_push) - (QPTR_W+1)'(w_pop);
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (QPTR_W+1)'(QDEPTH))
        else $error("queue count beyond depth");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) && !w_push |=> (r_count == '0))
        else $error("queue underflow");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push && !w_pop |=> r_count == $past(r_count) + (QPTR_W+1)'(1))
        else $error("queue count missed a push");

endmodule

// ===== design/gmcp_back.sv =====
// ----------------------------------------------------------------------------
// gmcp_back
// Row buffer, left sum and the add/compare that builds each cell's best sum.
// One stage reads the row buffer, the next computes and writes back.
// ----------------------------------------------------------------------------
module gmcp_back
    import gmcp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    input  t_cell_op    i_q_op,
    output logic        o_q_ready,
    gmcp_path_if.source o_path
);

    logic signed [SUM_W-1:0] r_row_sums [MAX_COLS];
    logic signed [SUM_W-1:0] r_rd_data;
    logic signed [SUM_W-1:0] r_left_sum;
    logic signed [SUM_W-1:0] r_out_cost;
    logic                    r_out_valid;
    logic                    r_s2_valid;
    logic                    r_s2_fwd;
    t_cell_op                r_s2_op;

    logic                    w_adv;
    logic                    w_pop;
    logic                    w_commit;
    logic signed [SUM_W-1:0] w_cost;
    logic signed [SUM_W-1:0] w_above;
    logic signed [SUM_W-1:0] w_sum;

    // The whole back end moves only when the output register can take a result.
    assign w_adv     = !r_out_valid || o_path.ready;
    assign o_q_ready = w_adv;
    assign w_pop     = w_adv && i_q_valid;
    assign w_commit  = w_adv && r_s2_valid;

    assign o_path.valid     = r_out_valid;
    assign o_path.path_cost = r_out_cost;

    // When the cell ahead wrote the same column in the cycle of the read,
    // its sum is the one now held in the left sum register.
    assign w_cost  = SUM_W'(r_s2_op.cost);
    assign w_above = r_s2_fwd ? r_left_sum : r_rd_data;

    always_comb begin
        priority if (r_s2_op.first_row && r_s2_op.first_col) begin
            w_sum = w_cost;
        end else if (r_s2_op.first_row) begin
            w_sum = r_left_sum + w_cost;
        end else if (r_s2_op.first_col) begin
            w_sum = w_above + w_cost;
        end else begin
            w_sum = w_cost + ((w_above < r_left_sum) ? w_above : r_left_sum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_rd_data <= r_row_sums[i_q_op.col];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_row_sums[r_s2_op.col] <= w_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_s2_op  <= i_q_op;
            r_s2_fwd <= r_s2_valid && (r_s2_op.col == i_q_op.col);
        end
        if (w_commit) begin
            r_left_sum <= w_sum;
        end
        if (w_commit && r_s2_op.last) begin
            r_out_cost <= w_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_s2_valid  <= w_pop;
            r_out_valid <= r_s2_valid && r_s2_op.last;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_s2_valid && r_s2_op.last))
        else $error("result raised without a last cell");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_valid && !w_adv |=> r_s2_valid && $stable(r_s2_op) && $stable(r_rd_data))
        else $error("stage two changed while stalled");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_commit && r_s2_op.last |=> r_out_valid && (r_out_cost == $past(w_sum)))
        else $error("last cell sum not captured");

endmodule

// ===== design/grid_min_cost_path_top.sv =====
// ----------------------------------------------------------------------------
// grid_min_cost_path_top
// Minimum right/down path cost through a grid of signed cell costs.
// ----------------------------------------------------------------------------
// Throughput: one cell per cycle unless o_path stalls; the row buffer is read
//   one stage ahead of the add/compare through one read and one write port.
// Output: the last cell passes the queue, stage two and the output register.
// Reset: grid sizes go to 1 and the position counters clear; the row buffer
//   is not cleared, since every entry is written before it is read.
// ----------------------------------------------------------------------------
module grid_min_cost_path_top
    import gmcp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    gmcp_cell_if.sink   i_cell,
    gmcp_path_if.source o_path,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output logic [31:0] o_prdata,
    output logic        o_pready
);

    logic [SIZE_W-1:0] r_grid_rows;
    logic [SIZE_W-1:0] r_grid_cols;
    logic              w_wr;
    logic              w_reg_sel;
    t_grid_cfg         w_cfg;
    logic              w_fq_valid;
    logic              w_fq_ready;
    t_cell_op          w_fq_op;
    logic              w_qb_valid;
    logic              w_qb_ready;
    t_cell_op          w_qb_op;

    assign o_pready  = 1'b1;
    assign w_wr      = i_psel && i_penable && i_pwrite;
    assign w_reg_sel = i_paddr[2];

    always_comb begin
        unique case (w_reg_sel)
            REG_GRID_ROWS: o_prdata = 32'(r_grid_rows);
            REG_GRID_COLS: o_prdata = 32'(r_grid_cols);
            default:       o_prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_rows <= SIZE_W'(1);
            r_grid_cols <= SIZE_W'(1);
        end else if (w_wr) begin
            if (w_reg_sel == REG_GRID_ROWS) begin
                r_grid_rows <= i_pwdata[SIZE_W-1:0];
            end else begin
                r_grid_cols <= i_pwdata[SIZE_W-1:0];
            end
        end
    end

    assign w_cfg.last_row = last_row_index(r_grid_rows);
    assign w_cfg.last_col = last_col_index(r_grid_cols);

    gmcp_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (w_cfg),
        .i_clear   (w_wr),
        .i_cell    (i_cell),
        .i_q_ready (w_fq_ready),
        .o_q_valid (w_fq_valid),
        .o_q_op    (w_fq_op)
    );

    gmcp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_fq_valid),
        .i_op    (w_fq_op),
        .o_ready (w_fq_ready),
        .o_valid (w_qb_valid),
        .o_op    (w_qb_op),
        .i_ready (w_qb_ready)
    );

    gmcp_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_qb_valid),
        .i_q_op    (w_qb_op),
        .o_q_ready (w_qb_ready),
        .o_path    (o_path)
    );

endmodule

// ===== tb/gmcp_path_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gmcp_path_checker
// Watches the cell, path and register ports of the grid minimum-cost-path
// block. It keeps its own row of best sums and grid position, predicts the
// path cost of every completed grid, and checks each result transaction
// against the oldest prediction.
// ----------------------------------------------------------------------------
module gmcp_path_checker
    import gmcp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    gmcp_cell_if        i_cell,
    gmcp_path_if        i_path,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    input  logic        i_pready,
    output int          o_errors,
    output int          o_pending
);

    logic [SIZE_W-1:0]       rows_reg;
    logic [SIZE_W-1:0]       cols_reg;
    logic signed [SUM_W-1:0] best_above [MAX_COLS];
    logic signed [SUM_W-1:0] sum_left;
    int                      next_col;
    int                      next_row;
    logic signed [SUM_W-1:0] expected_costs [$];
    int                      errors = 0;

    function automatic int effective_size(input logic [SIZE_W-1:0] size, input int limit);
        if (size == '0) begin
            return 1;
        end
        if (int'(size) > limit) begin
            return limit;
        end
        return int'(size);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        errors++;
    endtask

    // Accumulates one cell into the running sums and queues the path cost
    // when the cell closes the grid.
    task automatic accumulate_cell(input logic signed [COST_W-1:0] cost);
        int                      rows_eff;
        int                      cols_eff;
        int                      c;
        logic signed [SUM_W-1:0] above;
        logic signed [SUM_W-1:0] sum_now;
        rows_eff = effective_size(rows_reg, MAX_ROWS);
        cols_eff = effective_size(cols_reg, MAX_COLS);
        c = next_col;
        if (c >= cols_eff) begin
            c = 0;
        end
        if (next_row >= rows_eff) begin
            next_row = 0;
        end
        above = best_above[c];
        if (next_row == 0 && c == 0) begin
            sum_now = cost;
        end else if (next_row == 0) begin
            sum_now = sum_left + cost;
        end else if (c == 0) begin
            sum_now = above + cost;
        end else begin
            sum_now = cost + ((above < sum_left) ? above : sum_left);
        end
        best_above[c] = sum_now;
        sum_left = sum_now;
        c++;
        if (c >= cols_eff) begin
            c = 0;
            next_row++;
            if (next_row >= rows_eff) begin
                next_row = 0;
                expected_costs.push_back(sum_now);
            end
        end
        next_col = c;
    endtask

    always @(posedge i_clk) begin
        logic signed [SUM_W-1:0] want;
        if (!i_rst_n) begin
            rows_reg = SIZE_W'(1);
            cols_reg = SIZE_W'(1);
            sum_left = '0;
            next_col = 0;
            next_row = 0;
            expected_costs.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr[2] == REG_GRID_ROWS) begin
                    rows_reg = i_pwdata[SIZE_W-1:0];
                end else begin
                    cols_reg = i_pwdata[SIZE_W-1:0];
                end
                // Any register write restarts the grid.
                next_col = 0;
                next_row = 0;
            end
            if (i_cell.valid && i_cell.ready) begin
                accumulate_cell(i_cell.cell_cost);
            end
            if (i_path.valid && i_path.ready) begin
                if (expected_costs.size() == 0) begin
                    report_mismatch($sformatf("path cost %0d with no grid pending",
                                              i_path.path_cost));
                end else begin
                    want = expected_costs.pop_front();
                    if (i_path.path_cost !== want) begin
                        report_mismatch($sformatf("path_cost got %0d, want %0d",
                                                  i_path.path_cost, want));
                    end
                end
            end
        end
        o_pending = expected_costs.size();
        o_errors  = errors;
    end

endmodule

// ===== tb/tb_grid_min_cost_path_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_grid_min_cost_path_top
// Drives cell costs and grid sizes into the grid minimum-cost-path block:
// directed corner grids, a long output stall, then random grids with
// partial grids cut short by a size write. Results are checked by
// gmcp_path_checker.
// ----------------------------------------------------------------------------
module tb_grid_min_cost_path_top;
    import gmcp_pkg::*;

    localparam logic [2:0] ADDR_GRID_ROWS = {REG_GRID_ROWS, 2'b00};
    localparam logic [2:0] ADDR_GRID_COLS = {REG_GRID_COLS, 2'b00};
    localparam int         LONG_HOLD      = 250;
    localparam int         RANDOM_ITEMS   = 390;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          mismatches;
    int          pending;
    int          burst_left;
    int          hold_req;

    gmcp_cell_if cell_ch ();
    gmcp_path_if path_ch ();

    grid_min_cost_path_top uut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cell    (cell_ch),
        .o_path    (path_ch),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_pready  (pready)
    );

    gmcp_path_checker chk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cell    (cell_ch),
        .i_path    (path_ch),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .i_pready  (pready),
        .o_errors  (mismatches),
        .o_pending (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Path receiver: random stall patterns, plus a long hold-off on request.
    initial begin
        int mode;
        int mode_left;
        int hold_left;
        int hold_served;
        path_ch.ready = 1'b0;
        mode          = 0;
        mode_left     = 0;
        hold_left     = 0;
        hold_served   = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req != hold_served) begin
                hold_served = hold_req;
                hold_left   = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                path_ch.ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(16, 96);
                end
                mode_left--;
                case (mode)
                    0: path_ch.ready <= 1'b1;
                    1: path_ch.ready <= 1'($urandom_range(0, 1));
                    2: path_ch.ready <= ($urandom_range(0, 3) == 0);
                    default: path_ch.ready <= ((mode_left % 8) < 5);
                endcase
            end
        end
    end

    function automatic logic signed [COST_W-1:0] rand_cost();
        logic signed [COST_W-1:0] v;
        case ($urandom_range(0, 7))
            0: begin
                case ($urandom_range(0, 3))
                    0: v = 16'sh8000;
                    1: v = 16'sh7fff;
                    2: v = 16'sh0000;
                    default: v = 16'shffff;
                endcase
            end
            1, 2: begin
                // Narrow range, so that equal sums above and to the left occur.
                v = COST_W'($urandom_range(0, 16));
                v = v - 16'sd8;
            end
            default: v = COST_W'($urandom());
        endcase
        return v;
    endfunction

    function automatic logic [SIZE_W-1:0] pick_size();
        int k;
        k = $urandom_range(0, 15);
        if (k == 0) begin
            return '0;
        end else if (k <= 11) begin
            return SIZE_W'($urandom_range(1, 6));
        end else if (k <= 14) begin
            return SIZE_W'($urandom_range(7, 24));
        end
        return SIZE_W'($urandom_range(25, 64));
    endfunction

    // Offers one cell and returns at the edge where it is accepted.
    // The sender runs in bursts with idle gaps in between.
    task automatic send_cell(input logic signed [COST_W-1:0] cost);
        int gap;
        @(negedge i_clk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 32);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                cell_ch.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        cell_ch.valid     <= 1'b1;
        cell_ch.cell_cost <= cost;
        do @(posedge i_clk); while (!cell_ch.ready);
    endtask

    task automatic write_size(input logic [2:0] addr, input logic [SIZE_W-1:0] size);
        logic [31:0] noise;
        noise = $urandom();
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {noise[31:SIZE_W], size};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Waits for every expected path cost, then lets a partial grid drain.
    task automatic settle();
        @(negedge i_clk);
        cell_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    initial begin
        logic [SIZE_W-1:0] cur_rows;
        logic [SIZE_W-1:0] cur_cols;
        logic [SIZE_W-1:0] new_rows;
        logic [SIZE_W-1:0] new_cols;
        int                cells;
        int                grids;
        int                random_cells;
        int                left;
        int                k;

        cell_ch.valid     = 1'b0;
        cell_ch.cell_cost = '0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        i_rst_n           = 1'b0;
        burst_left        = 0;
        hold_req          = 0;
        random_cells      = 0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset sizes give a one-cell grid: every cost is its own path cost.
        send_cell(16'sh8000);
        send_cell(16'sh7fff);
        send_cell(16'sh0000);
        send_cell(16'shffff);
        send_cell(16'sh0001);
        settle();

        write_size(ADDR_GRID_ROWS, SIZE_W'(2));
        write_size(ADDR_GRID_COLS, SIZE_W'(3));
        send_cell(16'sh7fff);
        send_cell(16'sh8000);
        send_cell(16'sd100);
        send_cell(16'sh8000);
        send_cell(16'sd5);
        send_cell(16'sd5);
        settle();

        // The last cell sees equal sums above and to the left.
        write_size(ADDR_GRID_COLS, SIZE_W'(2));
        send_cell(16'sd1);
        send_cell(16'sd2);
        send_cell(16'sd2);
        send_cell(16'sd7);
        settle();

        // A grid cut short by a size write, then zero sizes acting as one.
        write_size(ADDR_GRID_ROWS, SIZE_W'(3));
        write_size(ADDR_GRID_COLS, SIZE_W'(3));
        repeat (4) send_cell(rand_cost());
        settle();
        write_size(ADDR_GRID_ROWS, '0);
        write_size(ADDR_GRID_COLS, '0);
        send_cell(16'sh8000);
        settle();

        // One-cell grids while the receiver holds off, so the block backs up.
        write_size(ADDR_GRID_ROWS, SIZE_W'(1));
        write_size(ADDR_GRID_COLS, SIZE_W'(1));
        cur_rows = SIZE_W'(1);
        cur_cols = SIZE_W'(1);
        hold_req++;
        repeat (40) send_cell(rand_cost());
        settle();

        while (random_cells < RANDOM_ITEMS) begin
            new_rows = pick_size();
            new_cols = pick_size();
            k = $urandom_range(0, 3);
            if (k == 0) begin
                new_cols = cur_cols;
            end else if (k == 1) begin
                new_rows = cur_rows;
            end
            if ((new_rows == 0 ? 1 : new_rows) * (new_cols == 0 ? 1 : new_cols) > 64) begin
                new_rows = SIZE_W'(1);
                k = 2;
            end
            if (k != 1) begin
                write_size(ADDR_GRID_ROWS, new_rows);
            end
            if (k != 0) begin
                write_size(ADDR_GRID_COLS, new_cols);
            end
            cur_rows = new_rows;
            cur_cols = new_cols;
            cells = (cur_rows == 0 ? 1 : cur_rows) * (cur_cols == 0 ? 1 : cur_cols);
            grids = $urandom_range(1, 3);
            left  = RANDOM_ITEMS - random_cells;
            if (grids * cells > left) begin
                grids = (left + cells - 1) / cells;
            end
            repeat (grids * cells) send_cell(rand_cost());
            random_cells += grids * cells;
            // Now and then leave a grid unfinished before the next size write.
            if (cells > 1 && random_cells < RANDOM_ITEMS && $urandom_range(0, 3) == 0) begin
                k = $urandom_range(1, cells - 1);
                repeat (k) send_cell(rand_cost());
                random_cells += k;
            end
            settle();
        end

        while (pending != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
        if (mismatches == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== grid_min_cost_path_top.f =====
design/gmcp_pkg.sv
design/gmcp_if.sv
design/gmcp_front.sv
design/gmcp_queue.sv
design/gmcp_back.sv
design/grid_min_cost_path_top.sv
tb/gmcp_path_checker.sv
tb/tb_grid_min_cost_path_top.sv
